>>> rtl/core/mte_pkg.sv
// Shared types and constants of the multi-tap echo filter.
// Used by mte_lane, mte_seq and multi_tap_echo_filter; depends on nothing.
`default_nettype none

package mte_pkg;

  // Parameter defaults
  localparam int CHANNELS_DEF     = 2;
  localparam int RING_SAMPLES_DEF = 262144;
  localparam int MAX_TAPS_DEF     = 4;

  // Item and register field widths
  localparam int DATA_W    = 24;  // Q1.23 samples
  localparam int GAIN_W    = 16;  // Q0.16 tap gains, Q2.14 mixes
  localparam int DELAY_W   = 16;
  localparam int TAPS_W    = 3;
  localparam int RSIZE_W   = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 19;
  localparam int LANES     = 4;   // samples per item

  // Datapath widths
  localparam int MAC_W     = DATA_W + GAIN_W + 1;  // one tap product
  localparam int ECHO_W    = 42;                   // sum of up to three tap products
  localparam int SPLIT     = 21;                   // echo split for the wet multiply
  localparam int HI_W      = ECHO_W - SPLIT + GAIN_W + 1;
  localparam int LO_W      = SPLIT + GAIN_W;
  localparam int DRY_W     = DATA_W + GAIN_W + 1;
  localparam int ACC_W     = 60;
  localparam int DRY_SHIFT = 16;
  localparam int FRAC_SHIFT = 30;
  localparam int ROW_MATH_W = 18;                  // ring rows, offsets and their sums

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_SAMPLES  = 3'd0,
    CFG_TAP_COUNT      = 3'd1,
    CFG_RING_SIZE      = 3'd2,
    CFG_TAP_GAIN_ONE   = 3'd3,
    CFG_TAP_GAIN_TWO   = 3'd4,
    CFG_TAP_GAIN_THREE = 3'd5,
    CFG_DRY_MIX        = 3'd6,
    CFG_WET_MIX        = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [RSIZE_W-1:0] RING_SIZE_RST = 19'd4;
  localparam logic [GAIN_W-1:0]  DRY_MIX_RST   = 16'd16384;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_TAP,
    SEQ_FLUSH,
    SEQ_DONE
  } seq_state_t;

  // Sequencer to lanes
  typedef struct packed {
    logic load;      // write group into ring, capture dry sample, clear echo
    logic mac_en;    // add delayed sample times tap gain to echo
    logic mul_en;    // form wet and dry products
    logic sum_en;    // add products and rounding constant
    logic res_load;  // result taken into the output register
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/multi_tap_echo_filter.sv
// Multi-tap echo filter: four lanes, one per sample of a group, each with its own ring slice.
// An item is accepted only while the sequencer is idle, so a new item waits until the last result
// is taken into the output register; the tap reads share each lane memory's one read port.
// Reset (rst, synchronous) restores the register defaults and clears ring pointers, fill
// counts and handshake state; ring contents are left as they are and need no clearing pass.
// Depends on mte_pkg, mte_seq, mte_lane and mte_ram.
`default_nettype none

module multi_tap_echo_filter #(
  parameter int CHANNELS     = mte_pkg::CHANNELS_DEF,
  parameter int RING_SAMPLES = mte_pkg::RING_SAMPLES_DEF,
  parameter int MAX_TAPS     = mte_pkg::MAX_TAPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_write,
  input  wire logic [mte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mte_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            channel,
  input  wire logic [mte_pkg::DATA_W-1:0]      sample_a,
  input  wire logic [mte_pkg::DATA_W-1:0]      sample_b,
  input  wire logic [mte_pkg::DATA_W-1:0]      sample_c,
  input  wire logic [mte_pkg::DATA_W-1:0]      sample_d,
  // result items
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [mte_pkg::DATA_W-1:0]      out_a,
  output logic      [mte_pkg::DATA_W-1:0]      out_b,
  output logic      [mte_pkg::DATA_W-1:0]      out_c,
  output logic      [mte_pkg::DATA_W-1:0]      out_d
);

  // Each lane memory holds one sample position of every ring row:
  // row address = channel * rows per ring + row within the ring.
  localparam int ROWS  = RING_SAMPLES / mte_pkg::LANES;
  localparam int DEPTH = CHANNELS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [mte_pkg::DELAY_W-1:0] delay_samples;
  logic [mte_pkg::TAPS_W-1:0]  tap_count;
  logic [mte_pkg::RSIZE_W-1:0] ring_size;
  logic [mte_pkg::GAIN_W-1:0]  tap_gain_one;
  logic [mte_pkg::GAIN_W-1:0]  tap_gain_two;
  logic [mte_pkg::GAIN_W-1:0]  tap_gain_three;
  logic [mte_pkg::GAIN_W-1:0]  dry_mix;
  logic [mte_pkg::GAIN_W-1:0]  wet_mix;

  mte_pkg::lane_ctl_t         ctl;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [mte_pkg::GAIN_W-1:0] gain;
  logic                       out_free;
  logic [mte_pkg::DATA_W-1:0] lane_in  [mte_pkg::LANES];
  logic [mte_pkg::DATA_W-1:0] lane_res [mte_pkg::LANES];

  // Take register writes; each register keeps only its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= '0;
      tap_count      <= '0;
      ring_size      <= mte_pkg::RING_SIZE_RST;
      tap_gain_one   <= '0;
      tap_gain_two   <= '0;
      tap_gain_three <= '0;
      dry_mix        <= mte_pkg::DRY_MIX_RST;
      wet_mix        <= '0;
    end else if (cfg_write) begin
      unique case (mte_pkg::cfg_idx_t'(cfg_index))
        mte_pkg::CFG_DELAY_SAMPLES:  delay_samples  <= cfg_data[mte_pkg::DELAY_W-1:0];
        mte_pkg::CFG_TAP_COUNT:      tap_count      <= cfg_data[mte_pkg::TAPS_W-1:0];
        mte_pkg::CFG_RING_SIZE:      ring_size      <= cfg_data[mte_pkg::RSIZE_W-1:0];
        mte_pkg::CFG_TAP_GAIN_ONE:   tap_gain_one   <= cfg_data[mte_pkg::GAIN_W-1:0];
        mte_pkg::CFG_TAP_GAIN_TWO:   tap_gain_two   <= cfg_data[mte_pkg::GAIN_W-1:0];
        mte_pkg::CFG_TAP_GAIN_THREE: tap_gain_three <= cfg_data[mte_pkg::GAIN_W-1:0];
        mte_pkg::CFG_DRY_MIX:        dry_mix        <= cfg_data[mte_pkg::GAIN_W-1:0];
        mte_pkg::CFG_WET_MIX:        wet_mix        <= cfg_data[mte_pkg::GAIN_W-1:0];
      endcase
    end
  end

  // The output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // Sequencer: accepts an item when idle, writes the group, then walks taps 1..MAX_TAPS-1,
  // one lane memory read per cycle, and steps the lanes through the mix pipeline.
  mte_seq #(
    .CHANNELS     (CHANNELS),
    .RING_SAMPLES (RING_SAMPLES),
    .MAX_TAPS     (MAX_TAPS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel        (channel),
    .out_free       (out_free),
    .delay_samples  (delay_samples),
    .tap_count      (tap_count),
    .ring_size      (ring_size),
    .tap_gain_one   (tap_gain_one),
    .tap_gain_two   (tap_gain_two),
    .tap_gain_three (tap_gain_three),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .gain           (gain),
    .ctl            (ctl)
  );

  assign lane_in[0] = sample_a;
  assign lane_in[1] = sample_b;
  assign lane_in[2] = sample_c;
  assign lane_in[3] = sample_d;

  // Four lanes run in lockstep on the same row addresses
  for (genvar i = 0; i < mte_pkg::LANES; i++) begin : g_lane
    mte_lane #(
      .DEPTH (DEPTH)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (lane_in[i]),
      .rd_addr (rd_addr),
      .gain    (gain),
      .dry_mix (dry_mix),
      .wet_mix (wet_mix),
      .result  (lane_res[i])
    );
  end

  // Merge the lane results into one output item; hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_a <= lane_res[0];
      out_b <= lane_res[1];
      out_c <= lane_res[2];
      out_d <= lane_res[3];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mte_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/mte_lane.sv
// One sample lane: its slice of the delay rings, tap accumulator and dry/wet mix.
// Depends on mte_pkg and mte_ram.
`default_nettype none

module mte_lane #(
  parameter int DEPTH = 131072
) (
  input  wire logic                            clk,
  input  wire mte_pkg::lane_ctl_t              ctl,
  input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  wire logic [mte_pkg::DATA_W-1:0]      wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
  input  wire logic [mte_pkg::GAIN_W-1:0]      gain,
  input  wire logic [mte_pkg::GAIN_W-1:0]      dry_mix,
  input  wire logic [mte_pkg::GAIN_W-1:0]      wet_mix,
  output logic      [mte_pkg::DATA_W-1:0]      result
);

  logic        [mte_pkg::DATA_W-1:0] rd_data;
  logic        [mte_pkg::DATA_W-1:0] sample;
  logic signed [mte_pkg::MAC_W-1:0]  mac_prod;
  logic signed [mte_pkg::ECHO_W-1:0] echo;
  logic signed [mte_pkg::HI_W-1:0]   hi_prod;
  logic        [mte_pkg::LO_W-1:0]   lo_prod;
  logic signed [mte_pkg::DRY_W-1:0]  dry_prod;
  logic signed [mte_pkg::ACC_W-1:0]  t_hi;
  logic signed [mte_pkg::ACC_W-1:0]  t_lo;
  logic signed [mte_pkg::ACC_W-1:0]  t_dry;
  logic signed [mte_pkg::ACC_W-1:0]  sum;
  logic        [mte_pkg::ACC_W-mte_pkg::FRAC_SHIFT-1:0] q;

  mte_ram #(
    .WIDTH (mte_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.load),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign mac_prod = $signed(rd_data) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample <= wr_data;
      echo   <= '0;
    end else if (ctl.mac_en) begin
      echo <= echo + mte_pkg::ECHO_W'(mac_prod);
    end
    if (ctl.mul_en) begin
      // wet product split in two halves of the echo word
      hi_prod  <= $signed(echo[mte_pkg::ECHO_W-1:mte_pkg::SPLIT]) * $signed({1'b0, wet_mix});
      lo_prod  <= echo[mte_pkg::SPLIT-1:0] * wet_mix;
      dry_prod <= $signed(sample) * $signed({1'b0, dry_mix});
    end
    if (ctl.sum_en) begin
      sum <= t_hi + t_lo + t_dry + $signed(mte_pkg::ROUND_HALF);
    end
  end

  always_comb begin
    t_hi  = mte_pkg::ACC_W'(hi_prod) <<< mte_pkg::SPLIT;
    t_lo  = $signed({{(mte_pkg::ACC_W - mte_pkg::LO_W){1'b0}}, lo_prod});
    t_dry = mte_pkg::ACC_W'(dry_prod) <<< mte_pkg::DRY_SHIFT;
    q     = sum[mte_pkg::ACC_W-1:mte_pkg::FRAC_SHIFT];
    // saturate to 24 bits
    if (!q[$high(q)] && (|q[$high(q)-1:mte_pkg::DATA_W-1])) begin
      result = {1'b0, {(mte_pkg::DATA_W-1){1'b1}}};
    end else if (q[$high(q)] && !(&q[$high(q)-1:mte_pkg::DATA_W-1])) begin
      result = {1'b1, {(mte_pkg::DATA_W-1){1'b0}}};
    end else begin
      result = q[mte_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mte_seq.sv
// Sequencer: per-channel ring pointers, write address, tap read addresses and lane control.
// Depends on mte_pkg.
`default_nettype none

module mte_seq #(
  parameter int CHANNELS     = mte_pkg::CHANNELS_DEF,
  parameter int RING_SAMPLES = mte_pkg::RING_SAMPLES_DEF,
  parameter int MAX_TAPS     = mte_pkg::MAX_TAPS_DEF,
  localparam int ROWS = RING_SAMPLES / mte_pkg::LANES,
  localparam int AW   = $clog2(CHANNELS * ROWS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          channel,
  input  wire logic                          out_free,
  input  wire logic [mte_pkg::DELAY_W-1:0]   delay_samples,
  input  wire logic [mte_pkg::TAPS_W-1:0]    tap_count,
  input  wire logic [mte_pkg::RSIZE_W-1:0]   ring_size,
  input  wire logic [mte_pkg::GAIN_W-1:0]    tap_gain_one,
  input  wire logic [mte_pkg::GAIN_W-1:0]    tap_gain_two,
  input  wire logic [mte_pkg::GAIN_W-1:0]    tap_gain_three,
  output logic      [AW-1:0]                 wr_addr,
  output logic      [AW-1:0]                 rd_addr,
  output logic      [mte_pkg::GAIN_W-1:0]    gain,
  output mte_pkg::lane_ctl_t                 ctl
);

  localparam int RW   = $clog2(ROWS);
  localparam int CR_W = $clog2(ROWS + 1);
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW   = mte_pkg::ROW_MATH_W;
  localparam int SZ_W = mte_pkg::RSIZE_W - 2;
  localparam logic [AW-1:0]   ROWS_A = AW'(ROWS);
  localparam logic [SZ_W-1:0] ROWS_S = SZ_W'(ROWS);
  localparam logic [1:0]      K_LAST = 2'(MAX_TAPS - 1);
  localparam logic [mte_pkg::TAPS_W-1:0] TAPS_MAX = mte_pkg::TAPS_W'(MAX_TAPS);

  mte_pkg::seq_state_t state, state_next;

  logic [RW-1:0]   write_pos [CHANNELS];
  logic [CR_W-1:0] fill      [CHANNELS];

  logic [CH_W-1:0] ch;
  logic [RW-1:0]   front_new;
  logic [CR_W-1:0] count;
  logic [1:0]      k;
  logic            mac_en;
  logic [mte_pkg::GAIN_W-1:0] mac_gain;
  logic            last1, last2, last3;

  logic            accept;
  logic [CH_W-1:0] ch_in;
  logic [SZ_W-1:0] size_raw;
  logic [SZ_W-1:0] size_clamp;
  logic [MW-1:0]   size;
  logic [MW-1:0]   front_cur;
  logic [MW-1:0]   front_inc;
  logic [MW-1:0]   count_cur;
  logic [MW-1:0]   count_upd;
  logic [MW-1:0]   kd;
  logic [MW-1:0]   off;
  logic [MW-1:0]   fnew;
  logic [MW-1:0]   rd_row;
  logic [mte_pkg::TAPS_W-1:0] taps;
  logic            tap_on;
  logic [mte_pkg::GAIN_W-1:0] tap_gain;

  // Effective ring size in rows of four, and the pointers of the incoming channel
  always_comb begin
    ch_in      = (CHANNELS == 1) ? '0 : CH_W'(channel);
    size_raw   = ring_size[mte_pkg::RSIZE_W-1:2];
    if (size_raw == '0) begin
      size_clamp = SZ_W'(1);
    end else if (size_raw > ROWS_S) begin
      size_clamp = ROWS_S;
    end else begin
      size_clamp = size_raw;
    end
    size       = MW'(size_clamp);
    front_cur  = MW'(write_pos[ch_in]);
    if (front_cur >= size) begin
      front_cur = '0;
    end
    front_inc  = (front_cur + MW'(1) == size) ? '0 : front_cur + MW'(1);
    count_cur  = MW'(fill[ch_in]);
    if (count_cur > size) begin
      count_cur = size;
    end
    count_upd  = (count_cur < size) ? count_cur + MW'(1) : count_cur;
    wr_addr    = AW'(ch_in) * ROWS_A + AW'(front_cur[RW-1:0]);
  end

  // Tap k: offset in rows, activity and read address behind the advanced front
  always_comb begin
    taps = (tap_count > TAPS_MAX) ? TAPS_MAX : tap_count;
    unique case (k)
      2'd1: begin
        kd = MW'(delay_samples);
        tap_gain = tap_gain_one;
      end
      2'd2: begin
        kd = MW'({delay_samples, 1'b0});
        tap_gain = tap_gain_two;
      end
      2'd3: begin
        kd = MW'(delay_samples) + MW'({delay_samples, 1'b0});
        tap_gain = tap_gain_three;
      end
      default: begin
        kd = '0;
        tap_gain = '0;
      end
    endcase
    off    = (kd + MW'(3)) >> 2;
    fnew   = MW'(front_new);
    tap_on = (mte_pkg::TAPS_W'(k) < taps) && (off < MW'(count));
    rd_row = (fnew >= off) ? fnew - off : fnew + size - off;
    rd_addr = AW'(ch) * ROWS_A + AW'(rd_row[RW-1:0]);
  end

  always_comb begin
    state_next   = state;
    accept       = 1'b0;
    ctl.load     = 1'b0;
    ctl.res_load = 1'b0;
    unique case (state)
      mte_pkg::SEQ_IDLE: begin
        if (in_valid && !rst) begin
          accept     = 1'b1;
          ctl.load   = 1'b1;
          state_next = mte_pkg::SEQ_TAP;
        end
      end
      mte_pkg::SEQ_TAP: begin
        if (k == K_LAST) begin
          state_next = mte_pkg::SEQ_FLUSH;
        end
      end
      mte_pkg::SEQ_FLUSH: begin
        if (last3) begin
          state_next = mte_pkg::SEQ_DONE;
        end
      end
      mte_pkg::SEQ_DONE: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          state_next   = mte_pkg::SEQ_IDLE;
        end
      end
      default: state_next = mte_pkg::SEQ_IDLE;
    endcase
    // hold the input off while busy and during reset
    in_stall   = rst || (state != mte_pkg::SEQ_IDLE);
    ctl.mac_en = mac_en;
    ctl.mul_en = last2;
    ctl.sum_en = last3;
    gain       = mac_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mte_pkg::SEQ_IDLE;
      k      <= 2'd1;
      mac_en <= 1'b0;
      last1  <= 1'b0;
      last2  <= 1'b0;
      last3  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        write_pos[i] <= '0;
        fill[i]      <= '0;
      end
    end else begin
      state  <= state_next;
      mac_en <= (state == mte_pkg::SEQ_TAP) && tap_on;
      last1  <= (state == mte_pkg::SEQ_TAP) && (k == K_LAST);
      last2  <= last1;
      last3  <= last2;
      if (state == mte_pkg::SEQ_TAP) begin
        k <= (k == K_LAST) ? 2'd1 : k + 2'd1;
      end
      if (accept) begin
        write_pos[ch_in] <= front_inc[RW-1:0];
        fill[ch_in]      <= count_upd[CR_W-1:0];
      end
    end
  end

  // Item context, no reset needed
  always_ff @(posedge clk) begin
    mac_gain <= tap_gain;
    if (accept) begin
      ch        <= ch_in;
      front_new <= front_inc[RW-1:0];
      count     <= count_upd[CR_W-1:0];
    end
  end

endmodule

`default_nettype wire
